### sv/csph_pkg.sv
// ----------------------------------------------------------------------------
// csph_pkg: shared constants and types
// Widths, CORDIC constants, register indexes and face codes for the
// cubed-sphere chart-to-point datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package csph_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int ANG_W      = 16;
    localparam int COORD_W    = 32;
    localparam int REG_W      = 31;
    localparam int FACE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // CORDIC, Q2.30 datapath
    localparam int CORDIC_ITERS = 24;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_ZW    = 33;
    localparam int ATAN_W       = 30;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;
    localparam logic [ATAN_W-1:0] ATAN_TAB [0:CORDIC_ITERS-1] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127
    };

    // tangent divide: |sin| << 30 / cos
    localparam int TAN_QW = 32;
    localparam int TAN_DW = 33;

    localparam int MAG_W  = 32;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;

    // radius scaling divide
    localparam int PROD_W = 63;
    localparam int SCL_QW = 31;
    localparam int SCL_DW = 33;

    localparam logic [REG_W-1:0] MAX_MAG = {REG_W{1'b1}};
    localparam logic [63:0] INV_SQRT3_Q32 = 64'd2479700525;

    localparam logic [CFG_IDX_W-1:0] CFG_FACE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 2'd2;

    localparam logic [FACE_W-1:0] FACE_1 = 3'd1;
    localparam logic [FACE_W-1:0] FACE_2 = 3'd2;
    localparam logic [FACE_W-1:0] FACE_3 = 3'd3;
    localparam logic [FACE_W-1:0] FACE_4 = 3'd4;
    localparam logic [FACE_W-1:0] FACE_5 = 3'd5;
    localparam logic [FACE_W-1:0] FACE_6 = 3'd6;

    // accept edge to result edge
    localparam int LATENCY = 127;

    typedef struct packed {
        logic                 xneg;
        logic                 yneg;
        logic [MAG_W-1:0]     xmag;
        logic [MAG_W-1:0]     ymag;
    } t_pt_side;

    typedef struct packed {
        logic hz;
        logic ovf;
        logic neg;
    } t_scl_side;

endpackage

`default_nettype wire

### sv/cubed_sphere_chart_to_point_unit.sv
// ----------------------------------------------------------------------------
// cubed_sphere_chart_to_point_unit: chart angles to sphere point
// Each accepted item gives an o_valid pulse with the result registered in
// r_cx/r_cy/r_cz. The pipeline is the CORDIC (25: angle load plus 24 steps),
// tangent divide (32), square root (32) and radius divide (31) pipelines plus
// 7 glue stages. Throughput: one item per cycle, busy stays low.
// Reset (synchronous, active low) clears all valid bits and loads the configuration registers with defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cubed_sphere_chart_to_point_unit #(
    parameter int FRAC_BITS = csph_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic signed [csph_pkg::ANG_W-1:0]       i_angle_xi,
    input  wire logic signed [csph_pkg::ANG_W-1:0]       i_angle_eta,
    output logic                                         o_valid,
    output logic signed [csph_pkg::COORD_W-1:0]          o_coord_x,
    output logic signed [csph_pkg::COORD_W-1:0]          o_coord_y,
    output logic signed [csph_pkg::COORD_W-1:0]          o_coord_z,
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [csph_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [csph_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int RGW = csph_pkg::REG_W;
    localparam int CW  = csph_pkg::CORDIC_W;
    localparam int TDW = csph_pkg::TAN_DW;
    localparam int TQW = csph_pkg::TAN_QW;
    localparam int MW  = csph_pkg::MAG_W;
    localparam int PW  = csph_pkg::PROD_W;
    localparam int SQW = csph_pkg::SCL_QW;
    localparam int SDW = csph_pkg::SCL_DW;
    localparam int OW  = csph_pkg::COORD_W;
    localparam int PSW = $bits(csph_pkg::t_pt_side);
    localparam int SSW = $bits(csph_pkg::t_scl_side);

    localparam logic [RGW-1:0] RADIUS_RST = RGW'(64'd1 << FRAC_BITS);
    localparam logic [63:0]    HALF_RST64 =
        ((64'd1 << FRAC_BITS) * csph_pkg::INV_SQRT3_Q32 + (64'd1 << 31)) >> 32;
    localparam logic [RGW-1:0] HALF_RST = HALF_RST64[RGW-1:0];

    // ---------------- configuration ----------------
    logic [csph_pkg::FACE_W-1:0] r_face;
    logic [RGW-1:0]              r_radius;
    logic [RGW-1:0]              r_half;
    logic [csph_pkg::FACE_W-1:0] cfg_face;

    assign o_cfg_ready = 1'b1;
    assign cfg_face    = i_cfg_data[csph_pkg::FACE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face   <= csph_pkg::FACE_1;
            r_radius <= RADIUS_RST;
            r_half   <= HALF_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                csph_pkg::CFG_FACE: begin
                    if (cfg_face >= csph_pkg::FACE_1 && cfg_face <= csph_pkg::FACE_6) begin
                        r_face <= cfg_face;
                    end
                end
                csph_pkg::CFG_RADIUS: r_radius <= i_cfg_data[RGW-1:0];
                csph_pkg::CFG_HALF:   r_half   <= i_cfg_data[RGW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- CORDIC ----------------
    logic                 accept;
    logic                 c_valid;
    logic signed [CW-1:0] xi_cos, xi_sin, eta_cos, eta_sin;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    csph_cordic u_cordic_xi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_angle (i_angle_xi),
        .o_valid (c_valid),
        .o_cos   (xi_cos),
        .o_sin   (xi_sin)
    );

    csph_cordic u_cordic_eta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_angle (i_angle_eta),
        .o_valid (),
        .o_cos   (eta_cos),
        .o_sin   (eta_sin)
    );

    // ---------------- tangent prep: clamp cos, magnitude of sin ----------------
    logic                 r_p_valid;
    logic [TDW-1:0]       r_xi_den, r_eta_den, r_xi_mag, r_eta_mag;
    logic                 r_xi_neg, r_eta_neg;
    logic signed [CW-1:0] xi_abs, eta_abs;

    assign xi_abs  = xi_sin[CW-1]  ? -xi_sin  : xi_sin;
    assign eta_abs = eta_sin[CW-1] ? -eta_sin : eta_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xi_den  <= (xi_cos  < 1) ? TDW'(1) : xi_cos[TDW-1:0];
        r_eta_den <= (eta_cos < 1) ? TDW'(1) : eta_cos[TDW-1:0];
        r_xi_mag  <= xi_abs[TDW-1:0];
        r_eta_mag <= eta_abs[TDW-1:0];
        r_xi_neg  <= xi_sin[CW-1];
        r_eta_neg <= eta_sin[CW-1];
    end

    // ---------------- tangent divide ----------------
    logic           t_valid;
    logic [TQW-1:0] xi_tan, eta_tan;
    logic           xi_tneg, eta_tneg;

    csph_div #(.QW(TQW), .DW(TDW), .SW(1)) u_div_tan_xi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_valid),
        .i_rem   ({2'b0, r_xi_mag[TDW-1:2]}),
        .i_low   ({r_xi_mag[1:0], 30'b0}),
        .i_den   (r_xi_den),
        .i_side  (r_xi_neg),
        .o_valid (t_valid),
        .o_quo   (xi_tan),
        .o_side  (xi_tneg)
    );

    csph_div #(.QW(TQW), .DW(TDW), .SW(1)) u_div_tan_eta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_valid),
        .i_rem   ({2'b0, r_eta_mag[TDW-1:2]}),
        .i_low   ({r_eta_mag[1:0], 30'b0}),
        .i_den   (r_eta_den),
        .i_side  (r_eta_neg),
        .o_valid (),
        .o_quo   (eta_tan),
        .o_side  (eta_tneg)
    );

    // ---------------- scale by half edge ----------------
    logic          r_m_valid;
    logic [MW-1:0] r_mx, r_my;
    logic          r_m_xneg, r_m_yneg;
    logic [PW-1:0] mx_prod, my_prod;

    assign mx_prod = {32'b0, r_half} * {31'b0, xi_tan};
    assign my_prod = {32'b0, r_half} * {31'b0, eta_tan};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx     <= mx_prod[61:30];
        r_my     <= my_prod[61:30];
        r_m_xneg <= xi_tneg;
        r_m_yneg <= eta_tneg;
    end

    // ---------------- squares and sum ----------------
    logic          r_q_valid, r_s_valid;
    logic [59:0]   r_sa;
    logic [61:0]   r_sx, r_sy;
    logic [61:0]   sa_prod;
    logic [63:0]   sx_prod, sy_prod;
    logic [csph_pkg::SUM_W-1:0] r_sum;
    csph_pkg::t_pt_side r_q_side, r_s_side;
    csph_pkg::t_pt_side rt_side;

    assign sa_prod = {31'b0, r_half} * {31'b0, r_half};
    assign sx_prod = {32'b0, r_mx} * {32'b0, r_mx};
    assign sy_prod = {32'b0, r_my} * {32'b0, r_my};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            r_q_valid <= r_m_valid;
            r_s_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa          <= sa_prod[61:2];
        r_sx          <= sx_prod[63:2];
        r_sy          <= sy_prod[63:2];
        r_q_side.xneg <= r_m_xneg;
        r_q_side.yneg <= r_m_yneg;
        r_q_side.xmag <= r_mx;
        r_q_side.ymag <= r_my;
        r_sum         <= {4'b0, r_sa} + {2'b0, r_sx} + {2'b0, r_sy};
        r_s_side      <= r_q_side;
    end

    // ---------------- square root ----------------
    logic                          rt_valid;
    logic [csph_pkg::ROOT_W-1:0]   rt_root;
    logic [PSW-1:0]                rt_side_v;

    csph_isqrt #(.SW(PSW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s_valid),
        .i_val   (r_sum),
        .i_side  (r_s_side),
        .o_valid (rt_valid),
        .o_root  (rt_root),
        .o_side  (rt_side_v)
    );

    assign rt_side = rt_side_v;

    // ---------------- radius products ----------------
    logic          r_n_valid;
    logic [PW-1:0] r_na, r_nx, r_ny;
    logic [SDW-1:0] r_n_den;
    logic          r_n_hz, r_n_xneg, r_n_yneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else begin
            r_n_valid <= rt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_na     <= {32'b0, r_radius} * {32'b0, r_half};
        r_nx     <= {32'b0, r_radius} * {31'b0, rt_side.xmag};
        r_ny     <= {32'b0, r_radius} * {31'b0, rt_side.ymag};
        r_n_den  <= {rt_root, 1'b0};
        r_n_hz   <= (rt_root == '0);
        r_n_xneg <= rt_side.xneg && (rt_side.xmag != '0);
        r_n_yneg <= rt_side.yneg && (rt_side.ymag != '0);
    end

    // ---------------- divide feed: overflow check ----------------
    logic                r_f_valid;
    logic [SDW-1:0]      r_fa_rem, r_fx_rem, r_fy_rem, r_f_den;
    logic [SQW-1:0]      r_fa_low, r_fx_low, r_fy_low;
    csph_pkg::t_scl_side r_fa_side, r_fx_side, r_fy_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= r_n_valid;
        end
    end

    // quotient saturates when product >> 31 reaches the divisor
    always_ff @(posedge i_clk) begin
        r_fa_rem      <= {1'b0, r_na[PW-1:SQW]};
        r_fx_rem      <= {1'b0, r_nx[PW-1:SQW]};
        r_fy_rem      <= {1'b0, r_ny[PW-1:SQW]};
        r_fa_low      <= r_na[SQW-1:0];
        r_fx_low      <= r_nx[SQW-1:0];
        r_fy_low      <= r_ny[SQW-1:0];
        r_f_den       <= r_n_den;
        r_fa_side.hz  <= r_n_hz;
        r_fx_side.hz  <= r_n_hz;
        r_fy_side.hz  <= r_n_hz;
        r_fa_side.ovf <= ({1'b0, r_na[PW-1:SQW]} >= r_n_den);
        r_fx_side.ovf <= ({1'b0, r_nx[PW-1:SQW]} >= r_n_den);
        r_fy_side.ovf <= ({1'b0, r_ny[PW-1:SQW]} >= r_n_den);
        r_fa_side.neg <= 1'b0;
        r_fx_side.neg <= r_n_xneg;
        r_fy_side.neg <= r_n_yneg;
    end

    // ---------------- radius divide ----------------
    logic           d_valid;
    logic [SQW-1:0] qa, qx, qy;
    logic [SSW-1:0] sa_v, sx_v, sy_v;

    csph_div #(.QW(SQW), .DW(SDW), .SW(SSW)) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_valid),
        .i_rem   (r_fa_rem),
        .i_low   (r_fa_low),
        .i_den   (r_f_den),
        .i_side  (r_fa_side),
        .o_valid (d_valid),
        .o_quo   (qa),
        .o_side  (sa_v)
    );

    csph_div #(.QW(SQW), .DW(SDW), .SW(SSW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_valid),
        .i_rem   (r_fx_rem),
        .i_low   (r_fx_low),
        .i_den   (r_f_den),
        .i_side  (r_fx_side),
        .o_valid (),
        .o_quo   (qx),
        .o_side  (sx_v)
    );

    csph_div #(.QW(SQW), .DW(SDW), .SW(SSW)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_valid),
        .i_rem   (r_fy_rem),
        .i_low   (r_fy_low),
        .i_den   (r_f_den),
        .i_side  (r_fy_side),
        .o_valid (),
        .o_quo   (qy),
        .o_side  (sy_v)
    );

    // ---------------- saturate, sign, face permutation ----------------
    function automatic logic signed [OW-1:0] finish(input logic [SQW-1:0] q,
                                                    input csph_pkg::t_scl_side sd);
        logic [OW-1:0] m;
        m = {1'b0, (sd.ovf ? csph_pkg::MAX_MAG : q)};
        if (sd.hz) begin
            finish = '0;
        end else if (sd.neg) begin
            finish = -$signed(m);
        end else begin
            finish = $signed(m);
        end
    endfunction

    logic signed [OW-1:0] vp, vx, vy;
    logic signed [OW-1:0] n_cx, n_cy, n_cz;
    logic signed [OW-1:0] r_cx, r_cy, r_cz;
    logic                 r_o_valid;

    assign vp = finish(qa, sa_v);
    assign vx = finish(qx, sx_v);
    assign vy = finish(qy, sy_v);

    always_comb begin
        unique case (r_face)
            csph_pkg::FACE_2: begin n_cx = -vx; n_cy = vp;  n_cz = vy;  end
            csph_pkg::FACE_3: begin n_cx = -vp; n_cy = -vx; n_cz = vy;  end
            csph_pkg::FACE_4: begin n_cx = vx;  n_cy = -vp; n_cz = vy;  end
            csph_pkg::FACE_5: begin n_cx = -vy; n_cy = vx;  n_cz = vp;  end
            csph_pkg::FACE_6: begin n_cx = vy;  n_cy = vx;  n_cz = -vp; end
            default:          begin n_cx = vp;  n_cy = vx;  n_cz = vy;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx <= n_cx;
        r_cy <= n_cy;
        r_cz <= n_cz;
    end

    assign o_valid   = r_o_valid;
    assign o_coord_x = r_cx;
    assign o_coord_y = r_cy;
    assign o_coord_z = r_cz;

endmodule

`default_nettype wire

### sv/csph_cordic.sv
// ----------------------------------------------------------------------------
// csph_cordic: pipelined CORDIC rotation
// One iteration per stage; gives cos and sin in Q2.30 of a Q1.15 angle.
// ----------------------------------------------------------------------------
`default_nettype none

module csph_cordic (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_valid,
    input  wire logic signed [csph_pkg::ANG_W-1:0]         i_angle,
    output logic                                           o_valid,
    output logic signed [csph_pkg::CORDIC_W-1:0]           o_cos,
    output logic signed [csph_pkg::CORDIC_W-1:0]           o_sin
);

    localparam int N  = csph_pkg::CORDIC_ITERS;
    localparam int CW = csph_pkg::CORDIC_W;
    localparam int ZW = csph_pkg::CORDIC_ZW;

    logic [N:0]                r_v;
    logic signed [CW-1:0]      r_x [0:N];
    logic signed [CW-1:0]      r_y [0:N];
    logic signed [ZW-1:0]      r_z [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= csph_pkg::CORDIC_K;
        r_y[0] <= '0;
        r_z[0] <= $signed({{2{i_angle[csph_pkg::ANG_W-1]}}, i_angle, 15'b0});
        for (int i = 0; i < N; i++) begin
            if (!r_z[i][ZW-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - $signed({3'b0, csph_pkg::ATAN_TAB[i]});
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + $signed({3'b0, csph_pkg::ATAN_TAB[i]});
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_cos   = r_x[N];
    assign o_sin   = r_y[N];

endmodule

`default_nettype wire

### sv/csph_div.sv
// ----------------------------------------------------------------------------
// csph_div: pipelined restoring divider
// One quotient bit per stage. Partial remainder must start below divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module csph_div #(
    parameter int QW = 32,
    parameter int DW = 33,
    parameter int SW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [DW-1:0]   i_rem,
    input  wire logic [QW-1:0]   i_low,
    input  wire logic [DW-1:0]   i_den,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_valid,
    output logic [QW-1:0]        o_quo,
    output logic [SW-1:0]        o_side
);

    logic [QW-1:0]  r_v;
    logic [DW-1:0]  r_rem  [0:QW-1];
    logic [QW-1:0]  r_low  [0:QW-1];
    logic [QW-1:0]  r_quo  [0:QW-1];
    logic [DW-1:0]  r_den  [0:QW-1];
    logic [SW-1:0]  r_side [0:QW-1];
    logic [DW:0]    st     [0:QW-1];

    // {quotient bit, next remainder}
    function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nb,
                                             input logic [DW-1:0] den);
        logic [DW:0] t;
        t = {rem, nb};
        if (t >= {1'b0, den}) begin
            div_step = {1'b1, DW'(t - {1'b0, den})};
        end else begin
            div_step = {1'b0, t[DW-1:0]};
        end
    endfunction

    always_comb begin
        st[0] = div_step(i_rem, i_low[QW-1], i_den);
        for (int i = 1; i < QW; i++) begin
            st[i] = div_step(r_rem[i-1], r_low[i-1][QW-1], r_den[i-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= st[0][DW-1:0];
        r_low[0]  <= i_low << 1;
        r_quo[0]  <= {{(QW-1){1'b0}}, st[0][DW]};
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int i = 1; i < QW; i++) begin
            r_rem[i]  <= st[i][DW-1:0];
            r_low[i]  <= r_low[i-1] << 1;
            r_quo[i]  <= {r_quo[i-1][QW-2:0], st[i][DW]};
            r_den[i]  <= r_den[i-1];
            r_side[i] <= r_side[i-1];
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

`default_nettype wire

### sv/csph_isqrt.sv
// ----------------------------------------------------------------------------
// csph_isqrt: pipelined integer square root
// One root bit per stage, floor(sqrt) of a 64-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module csph_isqrt #(
    parameter int SW = 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic [csph_pkg::SUM_W-1:0]        i_val,
    input  wire logic [SW-1:0]                     i_side,
    output logic                                   o_valid,
    output logic [csph_pkg::ROOT_W-1:0]            o_root,
    output logic [SW-1:0]                          o_side
);

    localparam int RW = csph_pkg::ROOT_W;
    localparam int VW = csph_pkg::SUM_W;

    logic [RW-1:0]  r_v;
    logic [VW-1:0]  r_rem  [0:RW-1];
    logic [RW-1:0]  r_res  [0:RW-1];
    logic [SW-1:0]  r_side [0:RW-1];
    logic [VW-1:0]  st_rem [0:RW-1];
    logic [RW-1:0]  st_res [0:RW-1];

    // try root bit k: (res + 2^k)^2 - res^2 = res*2^(k+1) + 2^(2k)
    function automatic logic [VW:0] sq_step(input logic [VW-1:0] rem, input logic [RW-1:0] res,
                                            input int k);
        logic [VW+1:0] trial;
        trial = ({{(VW+2-RW){1'b0}}, res} << (k + 1)) + ((VW+2)'(1) << (2 * k));
        if ({2'b0, rem} >= trial) begin
            sq_step = {1'b1, rem - trial[VW-1:0]};
        end else begin
            sq_step = {1'b0, rem};
        end
    endfunction

    always_comb begin
        logic [VW:0] s;
        s = sq_step(i_val, '0, RW - 1);
        st_rem[0] = s[VW-1:0];
        st_res[0] = s[VW] ? (RW'(1) << (RW - 1)) : '0;
        for (int i = 1; i < RW; i++) begin
            s = sq_step(r_rem[i-1], r_res[i-1], RW - 1 - i);
            st_rem[i] = s[VW-1:0];
            st_res[i] = s[VW] ? (r_res[i-1] | (RW'(1) << (RW - 1 - i))) : r_res[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[RW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int i = 0; i < RW; i++) begin
            r_rem[i] <= st_rem[i];
            r_res[i] <= st_res[i];
        end
        for (int i = 1; i < RW; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_res[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

`default_nettype wire

### sv/csph_checker.sv
// ----------------------------------------------------------------------------
// csph_port_checker: port-level checks
// Fixed latency in both directions, no stall, no out-of-range magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module csph_port_checker (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   start,
    input wire logic                                   busy,
    input wire logic                                   o_valid,
    input wire logic signed [csph_pkg::COORD_W-1:0]    o_coord_x,
    input wire logic signed [csph_pkg::COORD_W-1:0]    o_coord_y,
    input wire logic signed [csph_pkg::COORD_W-1:0]    o_coord_z
);

    localparam logic [csph_pkg::COORD_W-1:0] MOST_NEG =
        {1'b1, {(csph_pkg::COORD_W-1){1'b0}}};

    // every accepted item comes back as an o_valid result
    a_item_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(csph_pkg::LATENCY) o_valid)
        else $error("accepted item produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, csph_pkg::LATENCY))
        else $error("result without a matching item");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("unit stalled its input");

    // magnitudes saturate at 2^31-1
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_coord_x != MOST_NEG) && (o_coord_y != MOST_NEG)
                    && (o_coord_z != MOST_NEG))
        else $error("coordinate outside saturation range");

endmodule

bind cubed_sphere_chart_to_point_unit csph_port_checker u_csph_port_checker (.*);

`default_nettype wire
